[hw/rtl/ttc_pkg.sv]
// shared types, codes and the font table of the text tile console
`timescale 1ns / 1ps
package ttc_pkg;

	// request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_PUT   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_WIN_LEFT    = 3'd0;
	localparam logic [2:0] CFG_WIN_TOP     = 3'd1;
	localparam logic [2:0] CFG_WIN_WIDTH   = 3'd2;
	localparam logic [2:0] CFG_WIN_HEIGHT  = 3'd3;
	localparam logic [2:0] CFG_SCROLL_MODE = 3'd4;
	localparam logic [2:0] CFG_FONT_BASE   = 3'd5;

	localparam logic [7:0] CODE_NEWLINE  = 8'd10;
	localparam logic [7:0] CODE_SPACE    = 8'd32;
	localparam logic [7:0] GLYPH_UNKNOWN = 8'h1F;
	localparam logic [5:0] WIN_MAX       = 6'd32;

	localparam logic [7:0] GLYPH_TABLE [128] = '{
		8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
		8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
		8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
		8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
		8'h00, 8'h1E, 8'h2B, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h2A,
		8'h2E, 8'h2F, 8'h1F, 8'h1F, 8'h1D, 8'h1B, 8'h1C, 8'h2D,
		8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h28, 8'h29, 8'h2C, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
		8'h1F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
		8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
		8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
		8'h18, 8'h19, 8'h1A, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
		8'h1F, 8'h34, 8'h34, 8'h35, 8'h3D, 8'h36, 8'h37, 8'h38,
		8'h3C, 8'h39, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3C, 8'h3D,
		8'h37, 8'h38, 8'h34, 8'h36, 8'h39, 8'h3E, 8'h3E, 8'h3E,
		8'h3A, 8'h3E, 8'h3F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F
	};

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b00_0000_0001,
		ST_IDLE   = 10'b00_0000_0010,
		ST_REDUCE = 10'b00_0000_0100,
		ST_PUT    = 10'b00_0000_1000,
		ST_READ   = 10'b00_0001_0000,
		ST_FILL   = 10'b00_0010_0000,
		ST_SC_RD  = 10'b00_0100_0000,
		ST_SC_WR  = 10'b00_1000_0000,
		ST_BLANK  = 10'b01_0000_0000,
		ST_FIN    = 10'b10_0000_0000
	} state_t;

	// what follows the address reduction
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_PUT    = 2'd1,
		OP_READ   = 2'd2,
		OP_SCROLL = 2'd3
	} op_t;

	function automatic logic [5:0] clamp_size(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (v == 6'd0) r = 6'd1;
		else if (v > WIN_MAX) r = WIN_MAX;
		return r;
	endfunction

endpackage

[hw/rtl/text_tile_console_top.sv]
// text console over a square tile map: window clear, character put, scroll and tile read
//
// After reset the block sweeps the tile map to zero, one tile per cycle, with busy high. A
// request is taken when start is high and busy is low; busy then stays high until done pulses
// for one cycle with the result, which must be taken in that cycle. All work goes through one
// tile memory with a write and a read port and one compare/subtract unit that folds a linear
// map address into range, one subtract per cycle. Read: the reduction, then the memory read.
// Put: the reduction, then the tile write, or when the window scrolls a reduction of the
// window origin, one read and one write per moved tile, then the blanked row. Start: the
// reduction, then a fill of the window. Halted puts and unknown codes skip to the result.
// Configuration writes are always taken and must only come while busy is low.
`timescale 1ns / 1ps
module text_tile_console_top
	import ttc_pkg::*;
#(
	parameter int MAP_SIDE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [9:0]  read_addr,
	output logic        done,
	output logic [7:0]  tile_value,
	output logic        halted,
	output logic [4:0]  cursor_col,
	output logic [5:0]  cursor_row,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
	localparam int AW        = $clog2(MAP_CELLS);
	localparam int RAW_MAX_A = 63 * MAP_SIDE + 62;
	localparam int RAW_MAX_B = (RAW_MAX_A > 1023) ? RAW_MAX_A : 1023;
	localparam int RAW_MAX   = (RAW_MAX_B > MAP_CELLS) ? RAW_MAX_B : MAP_CELLS;
	localparam int RAW_W     = $clog2(RAW_MAX + 1);

	localparam logic [RAW_W-1:0] CELLS_R  = RAW_W'(MAP_CELLS);
	localparam logic [RAW_W-1:0] SIDE_R   = RAW_W'(MAP_SIDE);
	localparam logic [AW:0]      CELLS_A  = (AW+1)'(MAP_CELLS);
	localparam logic [AW:0]      STEP_ONE = (AW+1)'(1);
	localparam logic [AW:0]      STEP_ROW = (AW+1)'(MAP_SIDE);
	localparam logic [AW-1:0]    LAST_CELL = AW'(MAP_CELLS - 1);

	// config
	logic [4:0] win_left_q, win_top_q;
	logic [5:0] win_width_q, win_height_q;
	logic       scroll_mode_q;
	logic [7:0] font_base_q;

	state_t     state_q;
	op_t        op_q;
	logic [RAW_W-1:0] raw_q;
	logic [AW-1:0]    row_base_q, cell_q, clr_q;
	logic [4:0]       row_q, col_q;
	logic [7:0]       glyph_q;
	logic             glyph_we_q, scroll_q;
	logic [4:0]       cur_col_q;
	logic [5:0]       cur_row_q;
	logic             stopped_q;
	logic             done_q;
	logic [7:0]       tile_q;

	logic [7:0]    tile_mem [MAP_CELLS];
	logic [7:0]    mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata;

	logic [5:0] w, h;
	logic [4:0] cc;
	logic [5:0] cr, col1, col2, nrow;
	logic       wrap;
	logic       at_bottom;
	logic       use_cursor;
	logic [4:0] off_col;
	logic [5:0] off_row;
	logic [5:0] raw_row, raw_col;
	logic [RAW_W-1:0] raw_addr;
	logic [7:0] glyph_in, blank;
	logic       last_col, last_row;
	logic       accept;

	function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [AW:0] step);
		logic [AW:0] s;
		s = {1'b0, a} + step;
		if (s >= CELLS_A) s = s - CELLS_A;
		return s[AW-1:0];
	endfunction

	assign w = clamp_size(win_width_q);
	assign h = clamp_size(win_height_q);

	// clamp the cursor into the current window
	assign cc = ({1'b0, cur_col_q} >= w) ? 5'(w - 6'd1) : cur_col_q;
	assign cr = (cur_row_q >= h) ? (h - 6'd1) : cur_row_q;

	assign col1 = (char_code == CODE_NEWLINE) ? (w - 6'd1) : {1'b0, cc};
	assign col2 = col1 + 6'd1;
	assign wrap = (col2 == w);
	assign nrow = cr + {5'd0, wrap};
	assign at_bottom = (nrow == h);

	// linear map address of the window origin or of the cursor cell
	assign use_cursor = (state_q == ST_IDLE) && (req_type == REQ_PUT);
	assign off_col    = use_cursor ? cc : 5'd0;
	assign off_row    = use_cursor ? cr : 6'd0;
	assign raw_row    = {1'b0, win_top_q} + off_row;
	assign raw_col    = {1'b0, win_left_q} + {1'b0, off_col};
	assign raw_addr   = RAW_W'(raw_row) * SIDE_R + RAW_W'(raw_col);

	assign glyph_in = font_base_q + (char_code[7] ? GLYPH_UNKNOWN : GLYPH_TABLE[char_code[6:0]]);
	assign blank    = font_base_q + GLYPH_TABLE[CODE_SPACE[6:0]];

	assign last_col = ({1'b0, col_q} == (w - 6'd1));
	assign last_row = ({1'b0, row_q} == (h - 6'd1));

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign tile_value = tile_q;
	assign halted     = stopped_q;
	assign cursor_col = cur_col_q;
	assign cursor_row = cur_row_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_q;
		mem_wdata = blank;
		mem_raddr = cell_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'd0;
			end
			ST_REDUCE: begin
				mem_raddr = raw_q[AW-1:0];
			end
			ST_PUT: begin
				mem_we    = glyph_we_q;
				mem_wdata = glyph_q;
			end
			ST_FILL, ST_BLANK: begin
				mem_we = 1'b1;
			end
			ST_SC_RD: begin
				// source is the same column one map row further down
				mem_raddr = addr_add(cell_q, STEP_ROW);
			end
			ST_SC_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) tile_mem[mem_waddr] <= mem_wdata;
		mem_rd_q <= tile_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q    <= 5'd0;
			win_top_q     <= 5'd0;
			win_width_q   <= 6'd20;
			win_height_q  <= 6'd18;
			scroll_mode_q <= 1'b0;
			font_base_q   <= 8'd80;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIN_LEFT:    win_left_q    <= cfg_data[4:0];
				CFG_WIN_TOP:     win_top_q     <= cfg_data[4:0];
				CFG_WIN_WIDTH:   win_width_q   <= cfg_data[5:0];
				CFG_WIN_HEIGHT:  win_height_q  <= cfg_data[5:0];
				CFG_SCROLL_MODE: scroll_mode_q <= cfg_data[0];
				CFG_FONT_BASE:   font_base_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			op_q       <= OP_START;
			raw_q      <= '0;
			row_base_q <= '0;
			cell_q     <= '0;
			clr_q      <= '0;
			row_q      <= 5'd0;
			col_q      <= 5'd0;
			glyph_q    <= 8'd0;
			glyph_we_q <= 1'b0;
			scroll_q   <= 1'b0;
			cur_col_q  <= 5'd0;
			cur_row_q  <= 6'd0;
			stopped_q  <= 1'b0;
			done_q     <= 1'b0;
			tile_q     <= 8'd0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					done_q <= 1'b0;
					clr_q  <= clr_q + AW'(1);
					if (clr_q == LAST_CELL) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						unique case (req_type)
							REQ_START: begin
								cur_col_q <= 5'd0;
								cur_row_q <= 6'd0;
								stopped_q <= 1'b0;
								op_q      <= OP_START;
								raw_q     <= raw_addr;
								state_q   <= ST_REDUCE;
							end
							REQ_PUT: begin
								if (stopped_q) begin
									state_q <= ST_FIN;
								end else begin
									glyph_q    <= glyph_in;
									glyph_we_q <= (char_code >= CODE_SPACE);
									// past the bottom row: scroll or halt
									scroll_q   <= at_bottom && scroll_mode_q;
									stopped_q  <= at_bottom && !scroll_mode_q;
									cur_col_q  <= wrap ? 5'd0 : col2[4:0];
									cur_row_q  <= (at_bottom && scroll_mode_q) ?
										(h - 6'd1) : nrow;
									op_q    <= OP_PUT;
									raw_q   <= raw_addr;
									state_q <= ST_REDUCE;
								end
							end
							REQ_READ: begin
								op_q    <= OP_READ;
								raw_q   <= RAW_W'(read_addr);
								state_q <= ST_REDUCE;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_REDUCE: begin
					done_q <= 1'b0;
					if (raw_q >= CELLS_R) begin
						raw_q <= raw_q - CELLS_R;
					end else begin
						cell_q     <= raw_q[AW-1:0];
						row_base_q <= raw_q[AW-1:0];
						row_q      <= 5'd0;
						col_q      <= 5'd0;
						unique case (op_q)
							OP_START:  state_q <= ST_FILL;
							OP_PUT:    state_q <= ST_PUT;
							OP_READ:   state_q <= ST_READ;
							OP_SCROLL: state_q <= ST_SC_RD;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_READ: begin
					tile_q  <= mem_rd_q;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_PUT: begin
					done_q <= !scroll_q;
					if (scroll_q) begin
						// window origin goes through the same reduction
						op_q    <= OP_SCROLL;
						raw_q   <= raw_addr;
						state_q <= ST_REDUCE;
					end else begin
						tile_q  <= 8'd0;
						state_q <= ST_IDLE;
					end
				end
				ST_FILL, ST_SC_WR: begin
					done_q <= last_col && last_row && (state_q == ST_FILL);
					if (last_col && last_row) begin
						if (state_q == ST_FILL) begin
							tile_q  <= 8'd0;
							state_q <= ST_IDLE;
						end else begin
							// blank the last window row
							cell_q  <= row_base_q;
							col_q   <= 5'd0;
							state_q <= ST_BLANK;
						end
					end else begin
						if (last_col) begin
							row_q      <= row_q + 5'd1;
							col_q      <= 5'd0;
							row_base_q <= addr_add(row_base_q, STEP_ROW);
							cell_q     <= addr_add(row_base_q, STEP_ROW);
						end else begin
							col_q  <= col_q + 5'd1;
							cell_q <= addr_add(cell_q, STEP_ONE);
						end
						if (state_q == ST_SC_WR) state_q <= ST_SC_RD;
					end
				end
				ST_SC_RD: begin
					done_q  <= 1'b0;
					state_q <= ST_SC_WR;
				end
				ST_BLANK: begin
					done_q <= last_col;
					if (last_col) begin
						tile_q  <= 8'd0;
						state_q <= ST_IDLE;
					end else begin
						col_q  <= col_q + 5'd1;
						cell_q <= addr_add(cell_q, STEP_ONE);
					end
				end
				ST_FIN: begin
					tile_q  <= 8'd0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ttc_checker.sv]
// port-level checks of the text tile console and their binding
`timescale 1ns / 1ps
module ttc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       halted,
	input logic [4:0] cursor_col,
	input logic [5:0] cursor_row
);

	// every accepted transaction raises busy in the cycle after it is taken
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a transaction");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a busy cycle before it");

	// a halted console parks the cursor at column zero below the window
	a_halt_col: assert property (@(posedge clk) disable iff (!arst_n)
		done && halted |-> cursor_col == 5'd0)
		else $error("halted with cursor column off zero");

	a_run_row: assert property (@(posedge clk) disable iff (!arst_n)
		done && !halted |-> cursor_row <= 6'd31)
		else $error("cursor row past window while running");

endmodule

bind text_tile_console_top ttc_checker u_ttc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.halted     (halted),
	.cursor_col (cursor_col),
	.cursor_row (cursor_row)
);

[tb/testbench.sv]
// self-checking testbench for the text tile console: window clear, put, stop, scroll and read
`timescale 1ns / 1ps
module testbench;
	import ttc_pkg::*;

	localparam int MAP_SIDE  = 32;
	localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
	localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
	localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [7:0] tile;
		logic       halt;
		logic [4:0] col;
		logic [5:0] row;
	} console_out_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic [1:0] req_type  = '0;
	logic [7:0] char_code = '0;
	logic [9:0] read_addr = '0;
	logic       cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;
	logic       busy, done, halted, cfg_ready;
	logic [7:0] tile_value;
	logic [4:0] cursor_col;
	logic [5:0] cursor_row;

	text_tile_console_top #(.MAP_SIDE(MAP_SIDE)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .char_code(char_code), .read_addr(read_addr),
		.done(done), .tile_value(tile_value), .halted(halted),
		.cursor_col(cursor_col), .cursor_row(cursor_row),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the console state and its registers
	logic [7:0] shadow_map [MAP_CELLS];
	int         left_col, top_row, win_w, win_h;
	bit         scroll_on, frozen;
	logic [7:0] glyph_base;
	int         pen_col, pen_row;

	console_out_t pending_out [$];
	int           mismatches = 0;
	bit           steady = 1'b0;

	initial forever #2 clk = ~clk;

	initial begin
		#(64'd40_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int fit_size(input int v);
		if (v == 0) return 1;
		if (v > 32) return 32;
		return v;
	endfunction

	function automatic logic [7:0] tile_for(input logic [7:0] code);
		logic [7:0] g;
		g = (code < 8'd128) ? GLYPH_TABLE[code[6:0]] : GLYPH_UNKNOWN;
		return glyph_base + g;
	endfunction

	function automatic logic [9:0] map_index(input int r, input int c);
		return 10'(((top_row + r) * MAP_SIDE + left_col + c) % MAP_CELLS);
	endfunction

	function automatic console_out_t predict_console(input logic [1:0] kind,
			input logic [7:0] code, input logic [9:0] addr);
		console_out_t res;
		int w, h;
		logic [7:0] blank;
		w = fit_size(win_w);
		h = fit_size(win_h);
		blank = tile_for(CODE_SPACE);
		res.tile = 8'd0;
		case (kind)
		REQ_START: begin
			for (int r = 0; r < h; r++)
				for (int c = 0; c < w; c++)
					shadow_map[map_index(r, c)] = blank;
			pen_col = 0;
			pen_row = 0;
			frozen = 1'b0;
		end
		REQ_PUT: if (!frozen) begin
			if (pen_col >= w) pen_col = w - 1;
			if (pen_row >= h) pen_row = h - 1;
			if (code >= CODE_SPACE)
				shadow_map[map_index(pen_row, pen_col)] = tile_for(code);
			else if (code == CODE_NEWLINE)
				pen_col = w - 1;
			pen_col++;
			if (pen_col == w) begin
				pen_col = 0;
				pen_row++;
			end
			if (pen_row == h) begin
				if (!scroll_on) begin
					frozen = 1'b1;
				end else begin
					// rows move up in order, so a wrapped window reads rows already moved
					pen_row = h - 1;
					for (int r = 0; r < h; r++)
						for (int c = 0; c < w; c++)
							shadow_map[map_index(r, c)] = shadow_map[map_index(r + 1, c)];
					for (int c = 0; c < w; c++)
						shadow_map[map_index(h - 1, c)] = blank;
				end
			end
		end
		REQ_READ: res.tile = shadow_map[addr];
		default: ;
		endcase
		res.halt = frozen;
		res.col = pen_col[4:0];
		res.row = pen_row[5:0];
		return res;
	endfunction

	// result checker: every done pulse must match the oldest expectation
	always @(posedge clk) begin
		console_out_t want, got;
		if (arst_n && done) begin
			got = '{tile_value, halted, cursor_col, cursor_row};
			if (pending_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result tile %0d halt %0d col %0d row %0d",
						$realtime, got.tile, got.halt, got.col, got.row);
			end else begin
				want = pending_out.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: tile/halt/col/row exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							$realtime, want.tile, want.halt, want.col, want.row,
							got.tile, got.halt, got.col, got.row);
				end
			end
		end
	end

	// one transaction on the request port; start stays high on return
	task automatic send_request(input logic [1:0] kind, input logic [7:0] code,
			input logic [9:0] addr);
		if (!steady && $urandom_range(99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		char_code <= code;
		read_addr <= addr;
		do @(posedge clk); while (busy);
		pending_out.push_back(predict_console(kind, code, addr));
	endtask

	// block idle: nothing outstanding and busy low
	task automatic settle();
		start <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_WIN_LEFT:    left_col = data[4:0];
		CFG_WIN_TOP:     top_row = data[4:0];
		CFG_WIN_WIDTH:   win_w = data[5:0];
		CFG_WIN_HEIGHT:  win_h = data[5:0];
		CFG_SCROLL_MODE: scroll_on = data[0];
		CFG_FONT_BASE:   glyph_base = data;
		default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_char();
		int roll;
		roll = $urandom_range(99);
		if (roll < 12) return CODE_NEWLINE;
		if (roll < 22) return 8'($urandom_range(31));
		if (roll < 34) return 8'($urandom_range(128, 255));
		return 8'($urandom_range(32, 127));
	endfunction

	// window dimension, mostly small, with zero and oversize values now and then
	function automatic logic [7:0] rand_dim();
		int roll;
		roll = $urandom_range(99);
		if (roll < 75) return 8'($urandom_range(1, 6));
		if (roll < 85) return 8'($urandom_range(7, 32));
		if (roll < 90) return 8'd32;
		if (roll < 95) return 8'd0;
		return 8'($urandom_range(33, 255));
	endfunction

	// address inside the window or the row just below it
	function automatic logic [9:0] window_addr();
		return map_index($urandom_range(fit_size(win_h)), $urandom_range(fit_size(win_w) - 1));
	endfunction

	task automatic put_char(input logic [7:0] code);
		send_request(REQ_PUT, code, 10'($urandom));
	endtask

	task automatic read_tile(input logic [9:0] addr);
		send_request(REQ_READ, 8'($urandom), addr);
	endtask

	task automatic clear_window();
		send_request(REQ_START, 8'($urandom), 10'($urandom));
	endtask

	task automatic test_basic_requests();
		read_tile(10'd0);
		read_tile(10'd1023);
		send_request(REQ_UNKNOWN, 8'hFF, 10'h3FF);
		clear_window();
		put_char(8'h41);
		put_char(CODE_SPACE);
		put_char(8'h00);
		put_char(8'h1F);
		put_char(8'h7F);
		put_char(8'h80);
		put_char(8'hFF);
		put_char(CODE_NEWLINE);
		put_char(8'h7A);
		read_tile(map_index(0, 0));
		read_tile(map_index(0, 6));
		read_tile(map_index(1, 0));
		read_tile(10'd1023);
	endtask

	task automatic test_register_edges();
		write_reg(CFG_UNUSED_LO, 8'hA5);
		write_reg(CFG_UNUSED_HI, 8'h5A);
		write_reg(CFG_WIN_WIDTH, 8'd0);
		write_reg(CFG_WIN_HEIGHT, 8'd0);
		write_reg(CFG_WIN_LEFT, 8'd31);
		write_reg(CFG_WIN_TOP, 8'd31);
		write_reg(CFG_FONT_BASE, 8'd255);
		write_reg(CFG_SCROLL_MODE, 8'd0);
		clear_window();
		put_char(8'h42);
		put_char(8'h43);
		read_tile(map_index(0, 0));
		write_reg(CFG_WIN_WIDTH, 8'd63);
		write_reg(CFG_WIN_HEIGHT, 8'd255);
		write_reg(CFG_SCROLL_MODE, 8'd1);
		clear_window();
		read_tile(10'd0);
		read_tile(10'd1023);
	endtask

	// small windows in stop mode, filled until they halt, then restarted
	task automatic test_stop_fill();
		for (int round = 0; round < 4; round++) begin
			write_reg(CFG_WIN_WIDTH, 8'($urandom_range(1, 4)));
			write_reg(CFG_WIN_HEIGHT, 8'($urandom_range(1, 3)));
			write_reg(CFG_WIN_LEFT, round == 0 ? 8'd30 : 8'($urandom));
			write_reg(CFG_WIN_TOP, round == 0 ? 8'd31 : 8'($urandom));
			write_reg(CFG_SCROLL_MODE, 8'd0);
			write_reg(CFG_FONT_BASE, 8'($urandom));
			clear_window();
			repeat (14) put_char(rand_char());
			repeat (4) read_tile(window_addr());
			clear_window();
			repeat (3) put_char(rand_char());
		end
	endtask

	task automatic test_scroll_window();
		write_reg(CFG_WIN_WIDTH, 8'd4);
		write_reg(CFG_WIN_HEIGHT, 8'd3);
		write_reg(CFG_WIN_LEFT, 8'd29);
		write_reg(CFG_WIN_TOP, 8'd30);
		write_reg(CFG_SCROLL_MODE, 8'd1);
		clear_window();
		repeat (30) put_char(rand_char());
		repeat (6) read_tile(window_addr());
		// full-size window: the row below it wraps around the map to the window's top row
		write_reg(CFG_WIN_WIDTH, 8'd32);
		write_reg(CFG_WIN_HEIGHT, 8'd32);
		write_reg(CFG_WIN_LEFT, 8'd7);
		write_reg(CFG_WIN_TOP, 8'd5);
		clear_window();
		repeat (3) put_char(8'($urandom_range(32, 127)));
		repeat (33) put_char(CODE_NEWLINE);
		repeat (8) read_tile(window_addr());
		write_reg(CFG_WIN_WIDTH, 8'd1);
		write_reg(CFG_WIN_HEIGHT, 8'd1);
		clear_window();
		repeat (5) put_char(rand_char());
		read_tile(window_addr());
	endtask

	task automatic test_random_text(input int count);
		int roll;
		write_reg(CFG_WIN_WIDTH, rand_dim());
		write_reg(CFG_WIN_HEIGHT, rand_dim());
		write_reg(CFG_WIN_LEFT, 8'($urandom));
		write_reg(CFG_WIN_TOP, 8'($urandom));
		write_reg(CFG_SCROLL_MODE, 8'($urandom));
		write_reg(CFG_FONT_BASE, 8'($urandom));
		clear_window();
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 68) put_char(rand_char());
			else if (roll < 86) read_tile(window_addr());
			else if (roll < 92) read_tile(10'($urandom));
			else if (roll < 96) clear_window();
			else send_request(REQ_UNKNOWN, 8'($urandom), 10'($urandom));
		end
	endtask

	initial begin
		foreach (shadow_map[i]) shadow_map[i] = 8'd0;
		left_col = 0;
		top_row = 0;
		win_w = 20;
		win_h = 18;
		scroll_on = 1'b0;
		glyph_base = 8'd80;
		pen_col = 0;
		pen_row = 0;
		frozen = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_requests();
		test_register_edges();
		test_stop_fill();
		test_scroll_window();
		for (int phase = 0; phase < 12; phase++) begin
			steady = (phase == 5);
			test_random_text(phase == 5 ? 200 : 85);
		end
		steady = 1'b0;
		start <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
